### rtl/core/twif_pkg.sv
// ----------------------------------------------------------------------------
// twif_pkg
// shared types and constants for the trie word insert/find block
// ----------------------------------------------------------------------------
package twif_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int LIDX_W     = $clog2(ALPHABET_SIZE);
    localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int SLOT_W     = $clog2(LINK_DEPTH);

    localparam int LETTER_W = 5;
    localparam int STATUS_W = 2;
    localparam int MATCH_W  = 10;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [LIDX_W-1:0] t_lidx;

    typedef enum logic [1:0] {
        K_LETTER     = 2'd0,
        K_BAD_LETTER = 2'd1,
        K_END        = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_POOL_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic  is_find;
        t_kind kind;
        t_lidx lidx;
    } t_cmd;

endpackage

### rtl/core/twif_front.sv
// ----------------------------------------------------------------------------
// twif_front
// accepts input beats, classifies them as letter, bad letter or word end
// ----------------------------------------------------------------------------
module twif_front
    import twif_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // letter
    input  logic [0:0]          i_s_tuser,  // req_type
    input  logic                i_s_tlast,  // word_end
    output logic                o_q_valid,
    input  logic                i_q_ready,
    output t_cmd                o_q_cmd
);

    logic                r_valid;
    logic                n_valid;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic [LETTER_W-1:0] letter;
    logic                take;

    assign letter     = i_s_tdata[LETTER_W-1:0];
    assign o_s_tready = !r_valid || i_q_ready;
    assign take       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = r_valid;
    assign o_q_cmd    = r_cmd;

    always_comb begin
        n_valid         = r_valid && !i_q_ready;
        n_cmd           = r_cmd;
        if (take) begin
            n_valid         = 1'b1;
            n_cmd.is_find   = i_s_tuser[0];
            n_cmd.lidx      = LIDX_W'(letter);
            priority if (i_s_tlast) begin
                n_cmd.kind = K_END;
            end else if (32'(letter) >= ALPHABET_SIZE) begin
                n_cmd.kind = K_BAD_LETTER;
            end else begin
                n_cmd.kind = K_LETTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

endmodule

### rtl/core/twif_queue.sv
// ----------------------------------------------------------------------------
// twif_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module twif_queue
    import twif_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_cmd i_in_cmd,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_out_cmd
);

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] n_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W-1:0] n_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;
    logic              push;
    logic              pop;

    assign o_in_ready  = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_out_valid = r_cnt != '0;
    assign o_out_cmd   = r_entry[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (pop) begin
            n_rp = (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wp] <= i_in_cmd;
        end
    end

endmodule

### rtl/core/twif_back.sv
// ----------------------------------------------------------------------------
// twif_back
// walks the trie one command at a time over the node and link memories
// ----------------------------------------------------------------------------
module twif_back
    import twif_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  t_cmd                i_q_cmd,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // match_node
    output logic [STATUS_W-1:0] o_m_tuser   // status
);

    typedef enum logic [1:0] {
        S_FETCH = 2'b01,
        S_EXEC  = 2'b10
    } t_state;

    // node entry: word end mark on top, child present bits below
    logic [ALPHABET_SIZE:0] node_mem [NODE_COUNT];
    t_node                  link_mem [LINK_DEPTH];

    t_state                 r_state;
    t_state                 n_state;
    t_node                  r_cursor;
    t_node                  n_cursor;
    logic [FREE_W-1:0]      r_free;
    logic [FREE_W-1:0]      n_free;
    logic                   r_miss;
    logic                   n_miss;
    logic                   r_full;
    logic                   n_full;
    logic                   r_fresh;
    logic                   n_fresh;
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_status                r_status;
    t_status                n_status;
    t_node                  r_match;
    t_node                  n_match;

    t_cmd                   r_cmd;
    logic [SLOT_W-1:0]      r_slot;
    logic                   r_zero_rd;
    logic [ALPHABET_SIZE:0] r_node_rd;
    t_node                  r_link_rd;

    logic                   pop;
    logic                   out_free;
    logic                   exec_done;
    logic [SLOT_W-1:0]      fetch_slot;
    logic [ALPHABET_SIZE-1:0] present;
    logic [ALPHABET_SIZE-1:0] one_bit;
    logic                   mark;
    logic                   has_child;
    logic                   node_we;
    logic                   node_re;
    logic [ALPHABET_SIZE:0] node_wdata;
    logic                   link_we;
    logic                   link_re;

    assign o_q_ready  = r_state == S_FETCH;
    assign pop        = o_q_ready && i_q_valid;
    assign out_free   = !r_out_valid || i_m_tready;
    assign exec_done  = (r_state == S_EXEC) && ((r_cmd.kind != K_END) || out_free);
    assign fetch_slot = SLOT_W'(r_cursor) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(i_q_cmd.lidx);
    assign node_re    = pop && !r_fresh;
    assign link_re    = pop && (i_q_cmd.kind == K_LETTER);
    assign present    = r_zero_rd ? '0 : r_node_rd[ALPHABET_SIZE-1:0];
    assign mark       = !r_zero_rd && r_node_rd[ALPHABET_SIZE];
    assign has_child  = present[r_cmd.lidx];
    assign one_bit    = {{(ALPHABET_SIZE-1){1'b0}}, 1'b1};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'(MATCH_W'(r_match));
    assign o_m_tuser  = r_status;

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_free      = r_free;
        n_miss      = r_miss;
        n_full      = r_full;
        n_fresh     = r_fresh;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status    = r_status;
        n_match     = r_match;
        node_we     = 1'b0;
        node_wdata  = '0;
        link_we     = 1'b0;

        if (pop) begin
            n_state = S_EXEC;
            // a freshly allocated node is cleared on its first visit
            if (r_fresh) begin
                node_we = 1'b1;
                n_fresh = 1'b0;
            end
        end

        if (exec_done) begin
            n_state = S_FETCH;
            unique case (r_cmd.kind)
                K_LETTER: begin
                    if (!r_miss) begin
                        priority if (has_child) begin
                            n_cursor = r_link_rd;
                        end else if (r_cmd.is_find) begin
                            n_miss = 1'b1;
                        end else if (r_free >= FREE_W'(NODE_COUNT)) begin
                            n_miss = 1'b1;
                            n_full = 1'b1;
                        end else begin
                            node_we    = 1'b1;
                            node_wdata = {mark, present | (one_bit << r_cmd.lidx)};
                            link_we    = 1'b1;
                            n_cursor   = r_free[NODE_W-1:0];
                            n_free     = r_free + 1'b1;
                            n_fresh    = 1'b1;
                        end
                    end
                end
                K_BAD_LETTER: begin
                    n_miss = 1'b1;
                end
                K_END: begin
                    n_out_valid = 1'b1;
                    n_match     = '0;
                    if (r_cmd.is_find) begin
                        if (!r_miss && mark) begin
                            n_status = ST_FOUND;
                            n_match  = r_cursor;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end else begin
                        if (!r_miss) begin
                            node_we    = 1'b1;
                            node_wdata = {1'b1, present};
                            n_status   = ST_INSERTED;
                            n_match    = r_cursor;
                        end else begin
                            n_status = r_full ? ST_POOL_FULL : ST_NOT_FOUND;
                        end
                    end
                    n_cursor = '0;
                    n_miss   = 1'b0;
                    n_full   = 1'b0;
                    n_fresh  = 1'b0;
                end
                default: begin
                    n_miss = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_cursor    <= '0;
            r_free      <= FREE_W'(1);
            r_miss      <= 1'b0;
            r_full      <= 1'b0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_free      <= n_free;
            r_miss      <= n_miss;
            r_full      <= n_full;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_match  <= n_match;
        if (pop) begin
            r_cmd     <= i_q_cmd;
            r_slot    <= fetch_slot;
            r_zero_rd <= r_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[r_cursor] <= node_wdata;
        end
        if (node_re) begin
            r_node_rd <= node_mem[r_cursor];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[r_slot] <= r_free[NODE_W-1:0];
        end
        if (link_re) begin
            r_link_rd <= link_mem[fetch_slot];
        end
    end

    a_cursor_allocated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        FREE_W'(r_cursor) < r_free)
        else $error("cursor points past the allocated pool");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free <= FREE_W'(NODE_COUNT)) && (r_free != '0))
        else $error("free count out of range");

    a_full_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> r_miss)
        else $error("pool full flagged without a miss");

    a_end_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd.kind == K_END && out_free)
        |=> (r_cursor == '0 && !r_miss && !r_fresh && r_out_valid))
        else $error("word end did not rewind the walk");

endmodule

### rtl/core/trie_word_insert_find.sv
// ----------------------------------------------------------------------------
// trie_word_insert_find
// dictionary trie over a fixed node pool, insert and find one letter a beat
// ----------------------------------------------------------------------------
//  channel  dir  tdata            tuser        tlast
//  s        in   [4:0] letter     [0] req_type word_end
//  m        out  [9:0] match_node [1:0] status -
//
//  each beat goes through a fetch state in the walker, with the node and link
//  memory read, then an exec state with the update write before the next letter's cursor is known
//  a word end beat also waits for the result register to be free
//  the front stage and a 2-entry queue keep taking beats while the walker
//  or the result side stalls
//  reset is synchronous; no memory clearing pass, nodes are cleared on use
// ----------------------------------------------------------------------------
module trie_word_insert_find
    import twif_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // letter
    input  logic [0:0]          i_s_tuser,  // req_type
    input  logic                i_s_tlast,  // word_end
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // match_node
    output logic [STATUS_W-1:0] o_m_tuser   // status
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic b_valid;
    logic b_ready;
    t_cmd b_cmd;

    twif_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_q_valid  (f_valid),
        .i_q_ready  (f_ready),
        .o_q_cmd    (f_cmd)
    );

    twif_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (f_valid),
        .o_in_ready  (f_ready),
        .i_in_cmd    (f_cmd),
        .o_out_valid (b_valid),
        .i_out_ready (b_ready),
        .o_out_cmd   (b_cmd)
    );

    twif_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (b_valid),
        .o_q_ready  (b_ready),
        .i_q_cmd    (b_cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

### bench/trie_word_insert_find_tb.sv
// ----------------------------------------------------------------------------
// trie_word_insert_find_tb
// self-checking bench for the trie word insert/find block: words go in one
// letter beat at a time, a mirror of the node pool predicts each word's
// status and node, and result beats are compared in order under random
// stalls on both sides and a long result-side hold-off
// ----------------------------------------------------------------------------
module trie_word_insert_find_tb;
    import twif_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status status;
        t_node   node;
    } t_word_result;

    class trie_mirror;
        t_node                    link_mem [LINK_DEPTH];
        logic [ALPHABET_SIZE-1:0] kids     [NODE_COUNT];
        bit                       marked   [NODE_COUNT];
        int unsigned              used;
        t_node                    cur;
        bit                       missed;
        bit                       full;
        t_word_result             pending [$];
        int                       fails;

        function new();
            for (int n = 0; n < NODE_COUNT; n++) begin
                kids[n]   = '0;
                marked[n] = 1'b0;
            end
            used   = 1;
            cur    = '0;
            missed = 1'b0;
            full   = 1'b0;
            fails  = 0;
        endfunction

        function void note_beat(bit is_find, logic [LETTER_W-1:0] letter, bit last);
            t_word_result r;
            int           slot;
            if (!last) begin
                if (missed)
                    return;
                if (letter >= ALPHABET_SIZE) begin
                    missed = 1'b1;
                    return;
                end
                slot = cur * ALPHABET_SIZE + letter;
                if (kids[cur][letter]) begin
                    cur = link_mem[slot];
                    return;
                end
                if (is_find) begin
                    missed = 1'b1;
                    return;
                end
                if (used >= NODE_COUNT) begin
                    missed = 1'b1;
                    full   = 1'b1;
                    return;
                end
                kids[used]        = '0;
                marked[used]      = 1'b0;
                link_mem[slot]    = t_node'(used);
                kids[cur][letter] = 1'b1;
                cur               = t_node'(used);
                used++;
                return;
            end
            r.node = '0;
            if (is_find) begin
                if (!missed && marked[cur]) begin
                    r.status = ST_FOUND;
                    r.node   = cur;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end else begin
                if (!missed) begin
                    marked[cur] = 1'b1;
                    r.status    = ST_INSERTED;
                    r.node      = cur;
                end else begin
                    r.status = full ? ST_POOL_FULL : ST_NOT_FOUND;
                end
            end
            pending.push_back(r);
            cur    = '0;
            missed = 1'b0;
            full   = 1'b0;
        endfunction

        function void check_beat(logic [STATUS_W-1:0] status, logic [MATCH_W-1:0] node);
            t_word_result e;
            if (pending.size() == 0) begin
                $error("result beat with no word pending: status %0d match_node %0d",
                       status, node);
                fails++;
                return;
            end
            e = pending.pop_front();
            if (status !== e.status) begin
                $error("status expected %0d actual %0d", e.status, status);
                fails++;
            end
            if (node !== MATCH_W'(e.node)) begin
                $error("match_node expected %0d actual %0d", e.node, node);
                fails++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [4:0] letter
    logic [0:0]          s_tuser;   // [0] req_type
    logic                s_tlast;   // word_end
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [9:0] match_node
    logic [STATUS_W-1:0] m_tuser;   // [1:0] status

    trie_mirror pool;
    int         send_idle;
    int         recv_idle;
    int         hold_req;
    int         hold_cnt;

    trie_word_insert_find dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always #6 i_clk = ~i_clk;

    // result side: sample at the rising edge, drive ready at the falling edge
    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready)
            pool.check_beat(m_tuser, m_tdata[MATCH_W-1:0]);
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end else if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
        end
    end

    always @(negedge i_clk) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cnt > 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // entered at a falling edge, leaves at a falling edge with valid still high
    task automatic send_beat(input bit is_find, input logic [LETTER_W-1:0] letter,
                             input bit last);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(letter);
        s_tuser  <= is_find;
        s_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_tready);
        pool.note_beat(is_find, letter, last);
        @(negedge i_clk);
    endtask

    task automatic send_word(input bit is_find, input int len, input int hi);
        for (int i = 0; i < len; i++)
            send_beat(is_find, LETTER_W'($urandom_range(hi, 0)), 1'b0);
        send_beat(is_find, LETTER_W'($urandom_range(31, 0)), 1'b1);
    endtask

    task automatic rand_word();
        int kind;
        int len;
        int bad_at;
        bit is_find;
        kind    = $urandom_range(99);
        len     = $urandom_range(5, 0);
        is_find = 1'($urandom_range(1, 0));
        if (kind < 70) begin
            send_word(is_find, len, 3);
        end else if (kind < 80) begin
            send_word(is_find, len, ALPHABET_SIZE - 1);
        end else if (kind < 90) begin
            // well-formed word with one letter past z
            bad_at = $urandom_range(len, 0);
            for (int i = 0; i <= len; i++) begin
                if (i == bad_at)
                    send_beat(is_find, LETTER_W'($urandom_range(31, ALPHABET_SIZE)), 1'b0);
                else
                    send_beat(is_find, LETTER_W'($urandom_range(3, 0)), 1'b0);
            end
            send_beat(is_find, LETTER_W'($urandom_range(31, 0)), 1'b1);
        end else begin
            // noise: request type and letter vary beat by beat
            for (int i = 0; i < len; i++)
                send_beat(1'($urandom_range(1, 0)), LETTER_W'($urandom_range(31, 0)), 1'b0);
            send_beat(1'($urandom_range(1, 0)), LETTER_W'($urandom_range(31, 0)), 1'b1);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pool.pending.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        pool      = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        hold_req  = 0;
        hold_cnt  = 0;
        repeat (5) @(negedge i_clk);
        rst_n = 1'b1;
        @(negedge i_clk);

        // directed words
        send_beat(1'b1, 5'd0, 1'b1);        // empty find on a fresh root
        send_beat(1'b0, 5'd31, 1'b1);       // empty insert marks the root
        send_beat(1'b1, 5'd0, 1'b1);
        send_beat(1'b0, 5'd0, 1'b0);        // insert a
        send_beat(1'b0, 5'd0, 1'b1);
        send_beat(1'b0, 5'd25, 1'b0);       // insert z then find it
        send_beat(1'b0, 5'd0, 1'b1);
        send_beat(1'b1, 5'd25, 1'b0);
        send_beat(1'b1, 5'd0, 1'b1);
        send_beat(1'b1, 5'd1, 1'b0);        // find missing b
        send_beat(1'b1, 5'd0, 1'b1);
        send_beat(1'b0, 5'd2, 1'b0);        // insert with a letter past z
        send_beat(1'b0, 5'd31, 1'b0);
        send_beat(1'b0, 5'd4, 1'b0);
        send_beat(1'b0, 5'd0, 1'b1);
        send_beat(1'b1, 5'd26, 1'b0);       // find with a letter past z
        send_beat(1'b1, 5'd0, 1'b1);
        send_beat(1'b1, 5'd2, 1'b1);        // empty find of the marked root, the letter on a word end is ignored
        send_beat(1'b0, 5'd2, 1'b0);        // mixed types, find misses mid word
        send_beat(1'b1, 5'd16, 1'b0);
        send_beat(1'b0, 5'd8, 1'b0);
        send_beat(1'b0, 5'd0, 1'b1);
        send_beat(1'b0, 5'd0, 1'b0);        // insert a again
        send_beat(1'b0, 5'd0, 1'b1);
        wait_drain();

        send_idle = 7;
        recv_idle = 52;
        hold_req  = 300;
        repeat (35) rand_word();
        wait_drain();

        send_idle = 52;
        recv_idle = 7;
        repeat (35) rand_word();
        wait_drain();

        send_idle = 0;
        recv_idle = 0;
        repeat (35) rand_word();

        wait_drain();
        repeat (24) @(negedge i_clk);
        if (pool.fails == 0 && pool.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
rtl/core/twif_pkg.sv
rtl/core/twif_front.sv
rtl/core/twif_queue.sv
rtl/core/twif_back.sv
rtl/core/trie_word_insert_find.sv
bench/trie_word_insert_find_tb.sv
